FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, off while rst_ni is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication check built on the clocked form
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/madt_pkg.sv
// types and constants of the madt record parser
`timescale 1ns / 1ps
package madt_pkg;

  // override slot count checked against the source interrupt
  localparam int unsigned OverrideSlots = 16;

  // signature register reset value, "APIC" little-endian
  localparam logic [31:0] SigReset = 32'h4349_5041;

  // table layout
  localparam logic [31:0] RecordsBegin = 32'd44;
  localparam logic [31:0] HeaderLast   = 32'd7;
  localparam logic [7:0]  MinRecLen    = 8'd2;
  localparam logic [7:0]  TypeIoapic   = 8'd1;
  localparam logic [7:0]  TypeOverride = 8'd2;
  localparam logic [7:0]  IoapicMinLen = 8'd12;
  localparam logic [7:0]  OvrMinLen    = 8'd10;

  // result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // config register map
  localparam int unsigned ApbAddrW  = 3;
  localparam logic        RegSigIdx = 1'b0;

  typedef enum logic [2:0] {
    KIND_IOAPIC    = 3'd0,
    KIND_OVERRIDE  = 3'd1,
    KIND_SKIPPED   = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_TABLE_END = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  record_type;
    logic [7:0]  ioapic_id;
    logic [31:0] unit_address;
    logic [31:0] interrupt_base;
    logic [7:0]  bus_number;
    logic [7:0]  legacy_irq;
    logic [15:0] polarity_flags;
    logic        source_in_range;
    logic        table_ok;
    logic [31:0] length_seen;
    logic        last;
  } madt_result_t;

  // results written into the queue this cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // queue status seen by the input side
  typedef struct packed {
    logic           room;
    logic [QPtrW:0] level;
  } qstat_t;

endpackage

FILE: hw/rtl/madt_record_parser_top.sv
// top level of the madt record parser: config port, input register, decode, result queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Streams an ACPI interrupt controller table in one byte per transaction, from
// header byte zero (first_byte_i set restarts a table), and reports one result
// per I/O APIC, source override, skipped or malformed record plus a table end
// result with signature and checksum status. A byte is taken every cycle while
// the queue has room: it lands in an input register, is decoded against the
// running state, and any one or two results it gives enter a four-entry result queue,
// which hands out one result per cycle while out_ready_i is high; a result is
// written into the queue as its byte is decoded and shows from the queue head.
// Input back-pressure comes only from the queue, which must have two free
// entries for the decode to take a byte; only the last table byte can give two
// results. The expected signature must be written through the APB-style port at
// byte address 0 while no transaction is open; the block does not enforce this.
module madt_record_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [madt_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_byte_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [7:0]                    record_type_o,
  output logic [7:0]                    ioapic_id_o,
  output logic [31:0]                   unit_address_o,
  output logic [31:0]                   interrupt_base_o,
  output logic [7:0]                    bus_number_o,
  output logic [7:0]                    legacy_irq_o,
  output logic [15:0]                   polarity_flags_o,
  output logic                          source_in_range_o,
  output logic                          table_ok_o,
  output logic [31:0]                   length_seen_o,
  output logic                          last_o
);
  import madt_pkg::*;

  logic [31:0]  sig_q;
  logic         reg_idx;
  logic         in_vld_q;
  logic [7:0]   in_data_q;
  logic         in_first_q;
  logic         take;
  push_t        push;
  madt_result_t res0;
  madt_result_t res1;
  madt_result_t head;
  qstat_t       qstat;

  // config register
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegSigIdx) ? sig_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= SigReset;
    end else if (psel && penable && pwrite && pready && (reg_idx == RegSigIdx)) begin
      sig_q <= pwdata;
    end
  end

  // input register, drained whenever the queue has room
  assign take       = in_vld_q && qstat.room;
  assign in_ready_o = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q  <= data_byte_i;
      in_first_q <= first_byte_i;
    end
  end

  // byte decode
  madt_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .take_i               (take),
    .data_byte_i          (in_data_q),
    .first_byte_i         (in_first_q),
    .expected_signature_i (sig_q),
    .push_o               (push),
    .res0_o               (res0),
    .res1_o               (res1)
  );

  // result queue
  madt_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (out_ready_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .stat_o  (qstat)
  );

  // result fields
  assign kind_o            = head.kind;
  assign record_type_o     = head.record_type;
  assign ioapic_id_o       = head.ioapic_id;
  assign unit_address_o    = head.unit_address;
  assign interrupt_base_o  = head.interrupt_base;
  assign bus_number_o      = head.bus_number;
  assign legacy_irq_o      = head.legacy_irq;
  assign polarity_flags_o  = head.polarity_flags;
  assign source_in_range_o = head.source_in_range;
  assign table_ok_o        = head.table_ok;
  assign length_seen_o     = head.length_seen;
  assign last_o            = head.last;

  // checks
  `ASSERT_IMPLIES(a_second_needs_first, push.second, push.first, "second result without first")
  `ASSERT_IMPLIES(a_second_is_end, push.second, res1.kind == KIND_TABLE_END, "second result not end")
  `ASSERT_CLK(a_level_bound, qstat.level <= (QPtrW + 1)'(QDepth), "result queue overflow")
  `ASSERT_CLK(a_byte_held, in_vld_q && !take |=> in_vld_q, "held byte lost")

endmodule

FILE: hw/rtl/madt_rfifo.sv
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
module madt_rfifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  madt_pkg::push_t        push_i,
  input  madt_pkg::madt_result_t res0_i,
  input  madt_pkg::madt_result_t res1_i,
  input  logic                   pop_i,
  output madt_pkg::madt_result_t head_o,
  output logic                   valid_o,
  output madt_pkg::qstat_t       stat_o
);
  import madt_pkg::*;

  localparam int unsigned LvlW = QPtrW + 1;

  madt_result_t     mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic [QPtrW-1:0] wr_next;
  logic             pop;

  assign pop     = pop_i && valid_o;
  assign wr_next = wr_ptr_q + QPtrW'(1);

  // pointer and level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.first && push_i.second) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(2);
    end else if (push_i.first) begin
      wr_ptr_d = wr_next;
    end
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    level_d  = level_q + LvlW'(push_i.first) + LvlW'(push_i.second) - LvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  // head of queue and room for two more
  assign head_o       = mem_q[rd_ptr_q];
  assign valid_o      = (level_q != '0);
  assign stat_o.level = level_q;
  assign stat_o.room  = (level_q <= LvlW'(QDepth - 2));

endmodule

FILE: hw/rtl/madt_core.sv
// per-byte decode: header checks, record framing and result build
`timescale 1ns / 1ps
module madt_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic [31:0]            expected_signature_i,
  output madt_pkg::push_t        push_o,
  output madt_pkg::madt_result_t res0_o,
  output madt_pkg::madt_result_t res1_o
);
  import madt_pkg::*;

  // stored state
  logic [31:0] byte_offset_q, byte_offset_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [31:0] table_length_q, table_length_d;
  logic        signature_good_q, signature_good_d;
  logic [31:0] record_start_q, record_start_d;
  logic [7:0]  record_kind_byte_q, record_kind_byte_d;
  logic [7:0]  record_len_q, record_len_d;
  logic [7:0]  byte_two_q, byte_two_d;
  logic [7:0]  byte_three_q, byte_three_d;
  logic [31:0] word_low_q, word_low_d;
  logic [31:0] word_high_q, word_high_d;
  logic        parse_stopped_q, parse_stopped_d;
  logic        table_done_q, table_done_d;
  logic [7:0]  rel_q, rel_d;

  // state after an optional clear
  logic [31:0] off_c, tl_c, rs_c, wl_c, wh_c;
  logic [7:0]  sum_c, kb_c, len_c, b2_c, b3_c, rel_c;
  logic        sig_c, stop_c, done_c;

  logic [4:0]   lane;
  logic [4:0]   rel_lane;
  logic         rec_done;
  logic         malformed;
  logic         rec_emit;
  logic         end_emit;
  kind_e        rec_kind;
  madt_result_t rec_res;
  madt_result_t end_res;

  // a first byte starts from the cleared state
  always_comb begin
    if (first_byte_i) begin
      off_c  = '0;
      sum_c  = '0;
      tl_c   = '0;
      sig_c  = 1'b1;
      rs_c   = RecordsBegin;
      kb_c   = '0;
      len_c  = '0;
      b2_c   = '0;
      b3_c   = '0;
      wl_c   = '0;
      wh_c   = '0;
      stop_c = 1'b0;
      done_c = 1'b0;
      rel_c  = '0;
    end else begin
      off_c  = byte_offset_q;
      sum_c  = running_sum_q;
      tl_c   = table_length_q;
      sig_c  = signature_good_q;
      rs_c   = record_start_q;
      kb_c   = record_kind_byte_q;
      len_c  = record_len_q;
      b2_c   = byte_two_q;
      b3_c   = byte_three_q;
      wl_c   = word_low_q;
      wh_c   = word_high_q;
      stop_c = parse_stopped_q;
      done_c = table_done_q;
      rel_c  = rel_q;
    end
  end

  assign lane     = {off_c[1:0], 3'b000};
  assign rel_lane = {rel_c[1:0], 3'b000};

  // next state for one byte
  always_comb begin
    byte_offset_d      = off_c;
    running_sum_d      = sum_c;
    table_length_d     = tl_c;
    signature_good_d   = sig_c;
    record_start_d     = rs_c;
    record_kind_byte_d = kb_c;
    record_len_d       = len_c;
    byte_two_d         = b2_c;
    byte_three_d       = b3_c;
    word_low_d         = wl_c;
    word_high_d        = wh_c;
    parse_stopped_d    = stop_c;
    table_done_d       = done_c;
    rel_d              = rel_c;
    rec_done           = 1'b0;
    malformed          = 1'b0;
    end_emit           = 1'b0;

    if (!done_c) begin
      running_sum_d = sum_c + data_byte_i;

      // header: signature compare, then length bytes
      if (off_c[31:2] == '0) begin
        if (expected_signature_i[lane +: 8] != data_byte_i) begin
          signature_good_d = 1'b0;
        end
      end else if (off_c[31:3] == '0) begin
        table_length_d[lane +: 8] = tl_c[lane +: 8] | data_byte_i;
      end

      // record framing
      if (!stop_c && (off_c >= RecordsBegin)) begin
        if (rel_c == 8'd0) begin
          if (({1'b0, rs_c} + 33'd2) <= {1'b0, table_length_d}) begin
            record_kind_byte_d = data_byte_i;
            record_len_d       = '0;
            byte_two_d         = '0;
            byte_three_d       = '0;
            word_low_d         = '0;
            word_high_d        = '0;
          end
        end else if (rel_c == 8'd1) begin
          record_len_d = data_byte_i;
          if ((data_byte_i < MinRecLen) ||
              (({1'b0, rs_c} + {25'b0, data_byte_i}) > {1'b0, table_length_d})) begin
            malformed       = 1'b1;
            parse_stopped_d = 1'b1;
          end else if (data_byte_i == MinRecLen) begin
            rec_done = 1'b1;
          end
        end else begin
          if (rel_c == 8'd2) begin
            byte_two_d = data_byte_i;
          end else if (rel_c == 8'd3) begin
            byte_three_d = data_byte_i;
          end else if (rel_c < 8'd8) begin
            word_low_d[rel_lane +: 8] = wl_c[rel_lane +: 8] | data_byte_i;
          end else if (rel_c < 8'd12) begin
            word_high_d[rel_lane +: 8] = wh_c[rel_lane +: 8] | data_byte_i;
          end
          if (({1'b0, rel_c} + 9'd1) == {1'b0, len_c}) begin
            rec_done = 1'b1;
          end
        end
        rel_d = rec_done ? 8'd0 : rel_c + 8'd1;
        if (rec_done) begin
          record_start_d = rs_c + {24'b0, record_len_d};
        end
      end

      // last byte of the table
      end_emit = (off_c >= HeaderLast) &&
                 (({1'b0, off_c} + 33'd1) >= {1'b0, table_length_d});
      table_done_d = end_emit;
      if (!end_emit) begin
        byte_offset_d = off_c + 32'd1;
      end
    end
  end

  // record classification
  always_comb begin
    if (malformed) begin
      rec_kind = KIND_MALFORMED;
    end else if ((record_kind_byte_d == TypeIoapic) && (record_len_d >= IoapicMinLen)) begin
      rec_kind = KIND_IOAPIC;
    end else if ((record_kind_byte_d == TypeOverride) && (record_len_d >= OvrMinLen)) begin
      rec_kind = KIND_OVERRIDE;
    end else begin
      rec_kind = KIND_SKIPPED;
    end
  end

  // record result fields
  always_comb begin
    rec_res             = '0;
    rec_res.kind        = rec_kind;
    rec_res.record_type = record_kind_byte_d;
    rec_res.length_seen = table_length_d;
    case (rec_kind)
      KIND_IOAPIC: begin
        rec_res.ioapic_id      = byte_two_d;
        rec_res.unit_address   = word_low_d;
        rec_res.interrupt_base = word_high_d;
      end
      KIND_OVERRIDE: begin
        rec_res.interrupt_base  = word_low_d;
        rec_res.bus_number      = byte_two_d;
        rec_res.legacy_irq      = byte_three_d;
        rec_res.polarity_flags  = word_high_d[15:0];
        rec_res.source_in_range = ({1'b0, byte_three_d} < 9'(OverrideSlots));
      end
      default: begin
      end
    endcase
  end

  // table end result
  always_comb begin
    end_res             = '0;
    end_res.kind        = KIND_TABLE_END;
    end_res.table_ok    = signature_good_d && (running_sum_d == 8'd0);
    end_res.length_seen = table_length_d;
    end_res.last        = 1'b1;
  end

  // result ordering: record first, table end second
  assign rec_emit = malformed || rec_done;

  always_comb begin
    push_o.first  = take_i && (rec_emit || end_emit);
    push_o.second = take_i && rec_emit && end_emit;
    res1_o        = end_res;
    if (rec_emit) begin
      res0_o      = rec_res;
      res0_o.last = !end_emit;
    end else begin
      res0_o      = end_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q      <= '0;
      running_sum_q      <= '0;
      table_length_q     <= '0;
      signature_good_q   <= 1'b1;
      record_start_q     <= RecordsBegin;
      record_kind_byte_q <= '0;
      record_len_q       <= '0;
      byte_two_q         <= '0;
      byte_three_q       <= '0;
      word_low_q         <= '0;
      word_high_q        <= '0;
      parse_stopped_q    <= 1'b0;
      table_done_q       <= 1'b0;
      rel_q              <= '0;
    end else if (take_i) begin
      byte_offset_q      <= byte_offset_d;
      running_sum_q      <= running_sum_d;
      table_length_q     <= table_length_d;
      signature_good_q   <= signature_good_d;
      record_start_q     <= record_start_d;
      record_kind_byte_q <= record_kind_byte_d;
      record_len_q       <= record_len_d;
      byte_two_q         <= byte_two_d;
      byte_three_q       <= byte_three_d;
      word_low_q         <= word_low_d;
      word_high_q        <= word_high_d;
      parse_stopped_q    <= parse_stopped_d;
      table_done_q       <= table_done_d;
      rel_q              <= rel_d;
    end
  end

endmodule
